// ===== sv/ssfr_pkg.sv =====
// servo status frame receiver: shared types and constants
// no dependencies; used by every module of the block
package ssfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned TickW   = 16;
  localparam int unsigned StatusW = 3;

  localparam logic [ByteW-1:0]   SYNC_BYTE    = 8'hFF;
  localparam logic [TickW-1:0]   IDLE_MAX     = 16'hFFFF;
  localparam logic [TickW-1:0]   TIMEOUT_RST  = 16'd50;
  localparam logic [ByteW-1:0]   MIN_LEN      = 8'd2;

  localparam logic [1:0] OP_ARM  = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_TIMEOUT  = 3'd1;
  localparam logic [StatusW-1:0] ST_WRONG_ID = 3'd2;
  localparam logic [StatusW-1:0] ST_SHORT    = 3'd3;
  localparam logic [StatusW-1:0] ST_BAD_SUM  = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HUNT,
    PH_ID,
    PH_LEN,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [ByteW-1:0] expected_id;
    logic [ByteW-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0]   body_byte;
    logic               last_of_frame;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

// ===== sv/ssfr_in_stage.sv =====
// input register of the servo status frame receiver
// depends on ssfr_pkg
module ssfr_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ssfr_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output ssfr_pkg::item_t item
);
  import ssfr_pkg::*;

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ===== sv/ssfr_core.sv =====
// frame parser state and per-item update: sync hunt, id, length, body, checksum, timeout
// depends on ssfr_pkg
module ssfr_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_fire,
  input  ssfr_pkg::item_t                item,
  input  logic [ssfr_pkg::TickW-1:0]     timeout_ticks,
  output logic                           res_valid,
  output ssfr_pkg::result_t              res
);
  import ssfr_pkg::*;

  phase_t           phase, phase_next;
  logic             prior_was_sync, prior_was_sync_next;
  logic [ByteW-1:0] wanted_id, wanted_id_next;
  logic [ByteW-1:0] bytes_left, bytes_left_next;
  logic [ByteW-1:0] running_sum, running_sum_next;
  logic [TickW-1:0] idle_count, idle_count_next;

  logic [TickW-1:0] limit;
  logic [TickW-1:0] idle_inc;
  logic [ByteW-1:0] left_dec;
  logic [ByteW-1:0] b;

  assign b        = item.rx_byte;
  assign limit    = (timeout_ticks == '0) ? TickW'(1) : timeout_ticks;
  assign idle_inc = (idle_count == IDLE_MAX) ? idle_count : idle_count + TickW'(1);
  assign left_dec = bytes_left - ByteW'(1);

  always_comb begin
    phase_next          = phase;
    prior_was_sync_next = prior_was_sync;
    wanted_id_next      = wanted_id;
    bytes_left_next     = bytes_left;
    running_sum_next    = running_sum;
    idle_count_next     = idle_count;
    res_valid           = 1'b0;
    res                 = '{body_byte: '0, last_of_frame: 1'b0, status: ST_OK};

    if (item.opcode == OP_ARM) begin
      wanted_id_next      = item.expected_id;
      phase_next          = PH_HUNT;
      prior_was_sync_next = 1'b0;
      bytes_left_next     = '0;
      running_sum_next    = '0;
      idle_count_next     = '0;
    end else if (item.opcode == OP_TICK && phase != PH_IDLE) begin
      idle_count_next = idle_inc;
      if (idle_inc >= limit) begin
        phase_next = PH_IDLE;
        res_valid  = 1'b1;
        res        = '{body_byte: '0, last_of_frame: 1'b1, status: ST_TIMEOUT};
      end
    end else if (item.opcode == OP_BYTE && phase != PH_IDLE) begin
      idle_count_next = '0;
      unique case (phase)
        PH_HUNT: begin
          if (b == SYNC_BYTE && prior_was_sync) begin
            phase_next          = PH_ID;
            prior_was_sync_next = 1'b0;
          end else begin
            prior_was_sync_next = (b == SYNC_BYTE);
          end
        end
        PH_ID: begin
          if (b != wanted_id) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res        = '{body_byte: '0, last_of_frame: 1'b1, status: ST_WRONG_ID};
          end else begin
            running_sum_next = b;
            phase_next       = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b < MIN_LEN) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res        = '{body_byte: '0, last_of_frame: 1'b1, status: ST_SHORT};
          end else begin
            running_sum_next = running_sum + b;
            bytes_left_next  = b;
            phase_next       = PH_BODY;
          end
        end
        PH_BODY: begin
          bytes_left_next = left_dec;
          res_valid       = 1'b1;
          if (left_dec != '0) begin
            running_sum_next = running_sum + b;
            res = '{body_byte: b, last_of_frame: 1'b0, status: ST_OK};
          end else begin
            phase_next = PH_IDLE;
            res = '{body_byte: b, last_of_frame: 1'b1,
                    status: (b == ~running_sum) ? ST_OK : ST_BAD_SUM};
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      prior_was_sync <= 1'b0;
      wanted_id      <= '0;
      bytes_left     <= '0;
      running_sum    <= '0;
      idle_count     <= '0;
    end else if (item_fire) begin
      phase          <= phase_next;
      prior_was_sync <= prior_was_sync_next;
      wanted_id      <= wanted_id_next;
      bytes_left     <= bytes_left_next;
      running_sum    <= running_sum_next;
      idle_count     <= idle_count_next;
    end
  end

endmodule

// ===== sv/ssfr_out_stage.sv =====
// result register of the servo status frame receiver
// depends on ssfr_pkg
module ssfr_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  ssfr_pkg::result_t res,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output ssfr_pkg::result_t out_res
);
  import ssfr_pkg::*;

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// ===== sv/servo_status_frame_receiver.sv =====
// servo status frame receiver top level: config register, input stage, parser, result stage
// depends on ssfr_pkg, ssfr_in_stage, ssfr_core, ssfr_out_stage
//
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cfg_data[15:0] (timeout_ticks)
// in       in         in_valid / in_ready    opcode, expected_id, rx_byte
// out      out        out_valid / out_ready  body_byte, last_of_frame, status
//
// one item per cycle unless out stalls; an item's result is registered in the result register
// input register, combinational parser update, result register; cfg_ready is always high
// synchronous active-high reset clears control state, timeout_ticks returns to 50
// a stalled out channel holds the result register, and in_ready drops while the input
// register is also full
module servo_status_frame_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssfr_pkg::TickW-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [ssfr_pkg::ByteW-1:0]    expected_id,
  input  logic [ssfr_pkg::ByteW-1:0]    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ssfr_pkg::ByteW-1:0]    body_byte,
  output logic                          last_of_frame,
  output logic [ssfr_pkg::StatusW-1:0]  status
);
  import ssfr_pkg::*;

  logic [TickW-1:0] timeout_ticks;
  item_t            in_item;
  item_t            item;
  logic             item_valid;
  logic             advance;
  logic             item_fire;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  assign in_item   = '{opcode: opcode, expected_id: expected_id, rx_byte: rx_byte};
  assign item_fire = item_valid && advance;

  ssfr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ssfr_core u_core (
    .clk           (clk),
    .rst           (rst),
    .item_fire     (item_fire),
    .item          (item),
    .timeout_ticks (timeout_ticks),
    .res_valid     (res_valid),
    .res           (res)
  );

  ssfr_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .res_valid (item_valid && res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign body_byte     = out_res.body_byte;
  assign last_of_frame = out_res.last_of_frame;
  assign status        = out_res.status;

`ifndef SYNTH
  a_fail_ends_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last_of_frame)
    else $error("failure status without end of frame");

  a_fail_no_body: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_TIMEOUT || status == ST_WRONG_ID || status == ST_SHORT)
    |-> body_byte == '0)
    else $error("early failure carries a body byte");

  a_arm_silent: assert property (@(posedge clk) disable iff (rst)
    item_valid && item.opcode == OP_ARM |-> !res_valid)
    else $error("arm produced a result");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
